FILE: design/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants for pareto front ranking
// Pool geometry, lane count, sequencer states and the dominance test.
// ----------------------------------------------------------------------------
`default_nettype none
package pfr_pkg;

  localparam int POOL_SIZE      = 64;
  localparam int MAX_OBJECTIVES = 4;
  localparam int OBJ_W          = 32;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = 7;
  localparam int LANES          = 4;
  localparam int LANE_W         = 2;
  localparam int ROWS           = POOL_SIZE / LANES;
  localparam int ROW_W          = 4;
  localparam int NOBJ_W         = 3;

  typedef logic signed [OBJ_W-1:0] obj_t;
  typedef obj_t [MAX_OBJECTIVES-1:0] obj_vec_t;
  typedef logic [POOL_SIZE-1:0] pool_mask_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PIVOT,
    ST_SCAN,
    ST_TAIL,
    ST_WROW,
    ST_RREAD,
    ST_REVAL
  } state_t;

  // control from sequencer to the row merge stage
  typedef struct packed {
    logic             clr;
    logic             cap;
    logic [ROW_W-1:0] row;
  } merge_ctl_t;

  // a dominates b: no worse in every objective in use, strictly better in one
  function automatic logic dominates(obj_vec_t a, obj_vec_t b,
                                     logic [NOBJ_W-1:0] nobj);
    logic better;
    logic worse;
    better = 1'b0;
    worse  = 1'b0;
    for (int k = 0; k < MAX_OBJECTIVES; k++) begin
      if (NOBJ_W'(k) < nobj) begin
        if (a[k] < b[k]) better = 1'b1;
        if (a[k] > b[k]) worse  = 1'b1;
      end
    end
    return better & ~worse;
  endfunction

endpackage
`default_nettype wire

FILE: design/pfr_lane.sv
// ----------------------------------------------------------------------------
// pfr_lane: one dominance comparator lane
// Flags whether the candidate member dominates the current pivot member.
// ----------------------------------------------------------------------------
`default_nettype none
module pfr_lane (
  input  wire pfr_pkg::obj_vec_t              pivot,
  input  wire pfr_pkg::obj_vec_t              cand,
  input  wire                                 cand_ok,
  input  wire logic [pfr_pkg::NOBJ_W-1:0]     nobj,
  output logic                                dom
);
  import pfr_pkg::*;

  // candidate beats pivot
  assign dom = cand_ok & dominates(cand, pivot, nobj);

endmodule
`default_nettype wire

FILE: design/pfr_merge.sv
// ----------------------------------------------------------------------------
// pfr_merge: row merge stage
// Collects the lane flags of each scanned row into one dominator vector.
// ----------------------------------------------------------------------------
`default_nettype none
module pfr_merge (
  input  wire                                 clk,
  input  wire pfr_pkg::merge_ctl_t            ctl,
  input  wire logic [pfr_pkg::LANES-1:0]      bits,
  output pfr_pkg::pool_mask_t                 row_vec
);
  import pfr_pkg::*;

  pool_mask_t acc_r;
  pool_mask_t acc_nxt;

  // place lane flags at their member positions
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.cap) begin
      acc_nxt[ctl.row*LANES +: LANES] = bits;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign row_vec = acc_r;

endmodule
`default_nettype wire

FILE: design/pareto_front_ranking.sv
// ----------------------------------------------------------------------------
// pareto_front_ranking: non-dominated front sort of a loaded pool
// Loads members, builds the dominator matrix with parallel lanes, then
// peels fronts and emits one result per member.
// ----------------------------------------------------------------------------
// Loading takes one request per cycle. After the final member, ranking runs
// with in_ready low: the dominator matrix is built one pivot member at a
// time by four comparator lanes reading one row of the four member banks
// per cycle; fronts are then peeled over the single matrix read port, and
// peeling stalls while a result waits on out_ready. Results come front by
// front, in ascending member index within a front; the final one has out_last_result.
// Members beyond 64 are dropped and flagged in out_load_overflow.
`default_nettype none
module pareto_front_ranking (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire logic signed [31:0]        in_objective_first,
  input  wire logic signed [31:0]        in_objective_second,
  input  wire logic signed [31:0]        in_objective_third,
  input  wire logic signed [31:0]        in_objective_fourth,
  input  wire                            in_final_member,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [5:0]                     out_member_index,
  output logic [5:0]                     out_front_rank,
  output logic                           out_load_overflow,
  output logic                           out_last_result,
  input  wire                            cfg_wr_en,
  input  wire logic [2:0]                cfg_wr_data
);
  import pfr_pkg::*;

  // storage
  obj_vec_t   bank_mem [LANES][ROWS];
  pool_mask_t mat_mem [POOL_SIZE];

  state_t state_r, state_nxt;
  logic [NOBJ_W-1:0] cfg_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [IDX_W-1:0]  q_r, q_nxt;
  logic [ROW_W-1:0]  r_r, r_nxt;
  logic [ROW_W-1:0]  rd_row_r;
  logic              scan_vld_r;
  obj_vec_t          piv_r;
  obj_vec_t          rowd_r [LANES];
  pool_mask_t        mrow_r;
  pool_mask_t        done_r, done_nxt;
  pool_mask_t        front_r, front_nxt;
  logic [IDX_W-1:0]  rank_r, rank_nxt;
  logic [CNT_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic              ov_r, ov_nxt;
  logic [IDX_W-1:0]  oi_r, oi_nxt, orank_r, orank_nxt;
  logic              oovf_r, oovf_nxt, olast_r, olast_nxt;

  logic              accept, store_en;
  logic [NOBJ_W-1:0] nobj;
  logic [CNT_W-1:0]  n_last;
  logic [CNT_W-1:0]  rows_tmp;
  logic [ROW_W-1:0]  r_last;
  logic              q_end, in_front, slot_free, emit;
  pool_mask_t        emit_mask;
  logic [LANES-1:0]  lane_dom;
  pool_mask_t        row_vec;
  merge_ctl_t        mctl;
  obj_vec_t          in_vec;

  assign in_vec = {in_objective_fourth, in_objective_third,
                   in_objective_second, in_objective_first};
  assign accept   = in_valid & in_ready;
  assign store_en = accept & (cnt_r < CNT_W'(POOL_SIZE));
  assign nobj     = (cfg_r > NOBJ_W'(MAX_OBJECTIVES)) ? NOBJ_W'(MAX_OBJECTIVES) : cfg_r;
  assign n_last   = cnt_r - CNT_W'(1);
  assign rows_tmp = ((cnt_r + CNT_W'(LANES - 1)) >> LANE_W) - CNT_W'(1);
  assign r_last   = rows_tmp[ROW_W-1:0];
  assign q_end    = ({1'b0, q_r} == n_last);
  assign in_front = ~done_r[q_r] & ((mrow_r & ~done_r) == '0);
  assign slot_free = ~ov_r | out_ready;
  assign emit_mask = pool_mask_t'(1) << q_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (accept && in_final_member) state_nxt = ST_PIVOT;
      ST_PIVOT: state_nxt = ST_SCAN;
      ST_SCAN:  if (r_r == r_last) state_nxt = ST_TAIL;
      ST_TAIL:  state_nxt = ST_WROW;
      ST_WROW:  state_nxt = q_end ? ST_RREAD : ST_PIVOT;
      ST_RREAD: state_nxt = ST_REVAL;
      ST_REVAL: begin
        if (!in_front || slot_free) begin
          if (q_end && (emit_cnt_r + CNT_W'(in_front) == cnt_r)) state_nxt = ST_LOAD;
          else state_nxt = ST_RREAD;
        end
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // datapath control
  always_comb begin
    in_ready     = (state_r == ST_LOAD);
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    q_nxt        = q_r;
    r_nxt        = r_r;
    done_nxt     = done_r;
    front_nxt    = front_r;
    rank_nxt     = rank_r;
    emit_cnt_nxt = emit_cnt_r;
    emit         = 1'b0;
    mctl.clr     = (state_r == ST_PIVOT);
    mctl.cap     = scan_vld_r;
    mctl.row     = rd_row_r;
    case (state_r)
      ST_LOAD: begin
        if (store_en) cnt_nxt = cnt_r + CNT_W'(1);
        else if (accept) ovf_nxt = 1'b1;
        q_nxt = '0;
      end
      ST_PIVOT: r_nxt = '0;
      ST_SCAN:  r_nxt = r_r + ROW_W'(1);
      ST_WROW: begin
        q_nxt = q_end ? '0 : q_r + IDX_W'(1);
        if (q_end) begin
          done_nxt     = '0;
          front_nxt    = '0;
          rank_nxt     = '0;
          emit_cnt_nxt = '0;
        end
      end
      ST_REVAL: begin
        if (!in_front || slot_free) begin
          emit = in_front;
          if (in_front) begin
            front_nxt    = front_r | emit_mask;
            emit_cnt_nxt = emit_cnt_r + CNT_W'(1);
          end
          if (q_end) begin
            done_nxt  = done_r | front_nxt;
            front_nxt = '0;
            rank_nxt  = rank_r + IDX_W'(1);
            q_nxt     = '0;
            if (emit_cnt_nxt == cnt_r) begin
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end
          end else begin
            q_nxt = q_r + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    ov_nxt    = ov_r & ~out_ready;
    oi_nxt    = oi_r;
    orank_nxt = orank_r;
    oovf_nxt  = oovf_r;
    olast_nxt = olast_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      oi_nxt    = q_r;
      orank_nxt = rank_r;
      oovf_nxt  = ovf_r;
      olast_nxt = (emit_cnt_r + CNT_W'(1) == cnt_r);
    end
  end

  // comparator lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [IDX_W-1:0] cand_idx;
    assign cand_idx = {rd_row_r, LANE_W'(l)};
    pfr_lane u_lane (
      .pivot   (piv_r),
      .cand    (rowd_r[l]),
      .cand_ok ({1'b0, cand_idx} < cnt_r),
      .nobj    (nobj),
      .dom     (lane_dom[l])
    );
  end

  pfr_merge u_merge (
    .clk     (clk),
    .ctl     (mctl),
    .bits    (lane_dom),
    .row_vec (row_vec)
  );

  // member banks and matrix memory
  always_ff @(posedge clk) begin
    if (store_en) bank_mem[cnt_r[LANE_W-1:0]][cnt_r[IDX_W-1:LANE_W]] <= in_vec;
    if (state_r == ST_PIVOT) piv_r <= bank_mem[q_r[LANE_W-1:0]][q_r[IDX_W-1:LANE_W]];
    for (int l = 0; l < LANES; l++) rowd_r[l] <= bank_mem[l][r_r];
    rd_row_r <= r_r;
    if (state_r == ST_WROW) mat_mem[q_r] <= row_vec;
    if (state_r == ST_RREAD) mrow_r <= mat_mem[q_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    q_r      <= q_nxt;
    r_r      <= r_nxt;
    done_r   <= done_nxt;
    front_r  <= front_nxt;
    rank_r   <= rank_nxt;
    emit_cnt_r <= emit_cnt_nxt;
    oi_r     <= oi_nxt;
    orank_r  <= orank_nxt;
    oovf_r   <= oovf_nxt;
    olast_r  <= olast_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      cfg_r      <= NOBJ_W'(2);
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      scan_vld_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      scan_vld_r <= (state_r == ST_SCAN);
      ov_r       <= ov_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_member_index  = oi_r;
  assign out_front_rank    = orank_r;
  assign out_load_overflow = oovf_r;
  assign out_last_result   = olast_r;

endmodule
`default_nettype wire

FILE: design/pfr_checker.sv
// ----------------------------------------------------------------------------
// pfr_checker: port level checks for pareto front ranking
// Watches the request channels and the ranking run over time.
// ----------------------------------------------------------------------------
`default_nettype none
module pfr_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       in_final_member,
  input wire       out_valid,
  input wire       out_ready,
  input wire [5:0] out_member_index,
  input wire       out_last_result
);

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_member_index))
    else $error("result request changed while stalled");

  // final member starts ranking, loading stops
  a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final_member |=> !in_ready)
    else $error("input taken right after final member");

  // no loading while a run still has results to give
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> !in_ready)
    else $error("input ready during a ranking run");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result request after reset");

endmodule

bind pareto_front_ranking pfr_checker u_pfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_final_member  (in_final_member),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_member_index (out_member_index),
  .out_last_result  (out_last_result)
);
`default_nettype wire
